// ===== hw/rtl/clmx_pkg.sv =====
package clmx_pkg;

    // Default build values for the top level parameters.
    localparam int DEFAULT_AVERAGE_DEPTH = 32;
    localparam int DEFAULT_SAMPLE_BITS   = 12;

    // Field widths of the words on the ports.
    localparam int FIELD_W  = 12;
    localparam int DUTY_W   = 9;
    localparam int LEVEL_W  = 12;
    localparam int GAIN_W   = 8;
    localparam int START_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Mixing widths: dimmer and colour are scaled to 9 bits, the preset to 6.
    localparam int MIX_W    = 9;
    localparam int PRESET_W = 6;

    // Moving average slots, one ring per slot.
    localparam int NUM_AVG    = 5;
    localparam int AVG_DIMMER = 0;
    localparam int AVG_COLOUR = 1;
    localparam int AVG_PRESET = 2;
    localparam int AVG_CH1    = 3;
    localparam int AVG_CH2    = 4;

    localparam logic [MIX_W-1:0]  MIX_FULL  = 9'd511;
    localparam logic [DUTY_W-1:0] DUTY_FULL = 9'd256;

    // Register reset values.
    localparam logic [START_W-1:0] PWM_START_RESET   = 8'd24;
    localparam logic [LEVEL_W-1:0] ANALOG_FULL_RESET = 12'd255;
    localparam logic [GAIN_W-1:0]  GAIN_RESET        = 8'd242;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_START   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANALOG_FULL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_GAIN = 2'd2;

    typedef struct packed {
        logic [FIELD_W-1:0] dimmer_sample;
        logic [FIELD_W-1:0] colour_sample;
        logic [FIELD_W-1:0] preset_sample;
    } in_word_t;

    typedef struct packed {
        logic [DUTY_W-1:0]  first_soft_duty;
        logic [LEVEL_W-1:0] first_analog_level;
        logic [DUTY_W-1:0]  second_soft_duty;
        logic [LEVEL_W-1:0] second_analog_level;
    } out_word_t;

    // Configuration registers as seen by the output split.
    typedef struct packed {
        logic [START_W-1:0] pwm_start;
        logic [LEVEL_W-1:0] analog_full;
    } split_cfg_t;

    // One channel's output pair.
    typedef struct packed {
        logic [DUTY_W-1:0]  duty;
        logic [LEVEL_W-1:0] level;
    } split_out_t;

endpackage

// ===== hw/rtl/clmx_ring_mem.sv =====
module clmx_ring_mem #(
    parameter int DEPTH  = 32,
    parameter int WIDTH  = 60,
    parameter int ADDR_W = 5
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/clmx_avg_div.sv =====
module clmx_avg_div #(
    parameter int DEPTH = 32,
    parameter int SUM_W = 17,
    parameter int AVG_W = 12
) (
    input  logic [SUM_W-1:0] sum,
    output logic [AVG_W-1:0] avg
);

    // Division by the ring depth as a multiplication by a rounded-up
    // reciprocal. With K = SUM_W + log2(DEPTH) the quotient is exact for
    // every sum, and for a power-of-two depth it reduces to a shift.
    localparam int LG = $clog2(DEPTH);
    localparam int K  = SUM_W + LG;
    localparam logic [63:0] RECIP = ((64'd1 << K) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);
    localparam int M_W = SUM_W + 2;

    logic [SUM_W+M_W-1:0] prod;

    assign prod = (SUM_W+M_W)'(sum) * (SUM_W+M_W)'(RECIP[M_W-1:0]);
    assign avg  = AVG_W'(prod >> K);

endmodule

// ===== hw/rtl/clmx_split.sv =====
module clmx_split (
    input  logic [clmx_pkg::LEVEL_W-1:0] level_avg,
    input  clmx_pkg::split_cfg_t         cfg,
    output clmx_pkg::split_out_t         result
);
    import clmx_pkg::*;

    logic [LEVEL_W:0]   threshold;
    logic [LEVEL_W-1:0] over_start;

    assign threshold  = {1'b0, LEVEL_W'(cfg.pwm_start)} + {1'b0, cfg.analog_full};
    assign over_start = level_avg - LEVEL_W'(cfg.pwm_start);

    // Above the full analog range the duty is fully on and the analog
    // level carries the rest; between start and that point the duty
    // rises with the level, saturating at fully on; below start it is off.
    always_comb
    begin
        result.duty  = '0;
        result.level = cfg.analog_full;
        if ({1'b0, level_avg} > threshold)
        begin
            result.duty  = DUTY_FULL;
            result.level = over_start;
        end
        else if (level_avg >= LEVEL_W'(cfg.pwm_start))
        begin
            if (over_start > LEVEL_W'(DUTY_FULL))
            begin
                result.duty = DUTY_FULL;
            end
            else
            begin
                result.duty = over_start[DUTY_W-1:0];
            end
        end
    end

endmodule

// ===== hw/rtl/two_channel_led_color_mixer_unit.sv =====
// Two-channel LED color mixer. Each input word carries one sample period's
// dimmer, color and peak-preset readings; one output word with a soft PWM
// duty and an analog level per channel comes back for each. Words are taken
// one at a time: a word passes the read, three mix, filter and split steps
// before its result is registered, and no new word is accepted until the
// block is back in idle. The path is the single ring-memory row read at
// acceptance, the chain of three registered multiplies and the row
// write-back at the second averaging step. A finished result waits in the
// output register while the next word is accepted; a result that still waits
// when the following one is ready stalls the block. All five moving averages
// share one memory row per ring position; after reset the rows are treated as
// zero until the position first wraps, so no clearing pass is needed.
// Configuration writes are always taken (cfg_ready is tied high) and must be
// made only while the block is idle.
module two_channel_led_color_mixer_unit #(
    parameter int AVERAGE_DEPTH = clmx_pkg::DEFAULT_AVERAGE_DEPTH,
    parameter int SAMPLE_BITS   = clmx_pkg::DEFAULT_SAMPLE_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  clmx_pkg::in_word_t             in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output clmx_pkg::out_word_t            out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [clmx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [clmx_pkg::CFG_DATA_W-1:0] cfg_data
);
    import clmx_pkg::*;

    localparam int POS_W  = $clog2(AVERAGE_DEPTH);
    localparam int RING_W = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;
    localparam int SUM_W  = RING_W + POS_W;
    localparam int ROW_W  = NUM_AVG * RING_W;
    localparam int LANES  = 3;
    localparam logic [RING_W-1:0] SAMPLE_MASK = RING_W'((64'd1 << SAMPLE_BITS) - 64'd1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_MIX1  = 3'd2;
    localparam logic [2:0] ST_MIX2  = 3'd3;
    localparam logic [2:0] ST_MIX3  = 3'd4;
    localparam logic [2:0] ST_FILT  = 3'd5;
    localparam logic [2:0] ST_SPLIT = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic wrapped_reg, wrapped_next;
    logic [NUM_AVG-1:0][SUM_W-1:0] sum_reg, sum_next;

    logic [START_W-1:0] pwm_start_reg, pwm_start_next;
    logic [LEVEL_W-1:0] analog_full_reg, analog_full_next;
    logic [GAIN_W-1:0]  gain_reg, gain_next;

    logic [LANES-1:0][RING_W-1:0] samp_reg;
    logic [MIX_W-1:0]     d_reg, c_reg;
    logic [PRESET_W-1:0]  p_reg;
    logic [MIX_W-1:0]     warm_reg, cold_reg;
    logic [LEVEL_W-1:0]   ch1_reg, ch2_reg;
    logic [2*MIX_W-1:0]   cd_reg;
    logic [LEVEL_W-1:0]   f1_reg, f2_reg;

    logic      out_valid_reg, out_valid_next;
    out_word_t out_data_reg;

    logic accept;
    logic out_free;

    logic [ROW_W-1:0] rd_row;
    logic [NUM_AVG-1:0][RING_W-1:0] old_val, new_val;
    logic [LANES-1:0][SUM_W-1:0]  lane_sum, lane_upd;
    logic [LANES-1:0][RING_W-1:0] lane_old, lane_new, lane_avg;

    logic [RING_W+MIX_W-1:0]    d_scaled, c_scaled;
    logic [RING_W+PRESET_W-1:0] p_scaled;
    logic [MIX_W+PRESET_W-1:0]  warm_prod, cold_prod;
    logic [2*MIX_W-1:0]         ch1_prod;
    logic [2*MIX_W+GAIN_W-1:0]  ch2_prod;

    split_cfg_t split_cfg;
    split_out_t split1, split2;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Ring memory: one row per position holding all five averages' entries.
    clmx_ring_mem #(
        .DEPTH  (AVERAGE_DEPTH),
        .WIDTH  (ROW_W),
        .ADDR_W (POS_W)
    ) u_ring_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (pos_reg),
        .rd_data (rd_row),
        .wr_en   (state_reg == ST_FILT),
        .wr_addr (pos_reg),
        .wr_data (ROW_W'(new_val))
    );

    // A row not yet written since reset reads as zero.
    assign old_val = wrapped_reg ? rd_row : '0;

    always_comb
    begin
        new_val             = '0;
        new_val[AVG_DIMMER] = samp_reg[AVG_DIMMER];
        new_val[AVG_COLOUR] = samp_reg[AVG_COLOUR];
        new_val[AVG_PRESET] = samp_reg[AVG_PRESET];
        new_val[AVG_CH1]    = RING_W'(ch1_reg);
        new_val[AVG_CH2]    = RING_W'(ch2_reg);
    end

    // Averaging lanes: the three inputs first, then the two channels.
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            lane_sum[i] = sum_reg[i];
            lane_old[i] = old_val[i];
            lane_new[i] = new_val[i];
        end
        if (state_reg == ST_FILT)
        begin
            lane_sum[0] = sum_reg[AVG_CH1];
            lane_old[0] = old_val[AVG_CH1];
            lane_new[0] = new_val[AVG_CH1];
            lane_sum[1] = sum_reg[AVG_CH2];
            lane_old[1] = old_val[AVG_CH2];
            lane_new[1] = new_val[AVG_CH2];
        end
        for (int i = 0; i < LANES; i++)
        begin
            lane_upd[i] = lane_sum[i] - SUM_W'(lane_old[i]) + SUM_W'(lane_new[i]);
        end
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        clmx_avg_div #(
            .DEPTH (AVERAGE_DEPTH),
            .SUM_W (SUM_W),
            .AVG_W (RING_W)
        ) u_avg_div (
            .sum (lane_upd[g]),
            .avg (lane_avg[g])
        );
    end

    // Scaling of the input averages to the mixing widths.
    assign d_scaled = {lane_avg[AVG_DIMMER], MIX_W'(0)} >> SAMPLE_BITS;
    assign c_scaled = {lane_avg[AVG_COLOUR], MIX_W'(0)} >> SAMPLE_BITS;
    assign p_scaled = {lane_avg[AVG_PRESET], PRESET_W'(0)} >> SAMPLE_BITS;

    // Warm/cold split and dimming. The products never exceed 12 bits after
    // their shifts, so the channel ceiling of 4095 is never reached.
    assign warm_prod = (MIX_W+PRESET_W)'(MIX_FULL - c_reg) * (MIX_W+PRESET_W)'(p_reg);
    assign cold_prod = (MIX_W+PRESET_W)'(c_reg) * (MIX_W+PRESET_W)'(p_reg);
    assign ch1_prod  = (2*MIX_W)'(warm_reg) * (2*MIX_W)'(d_reg);
    assign ch2_prod  = (2*MIX_W+GAIN_W)'(cd_reg) * (2*MIX_W+GAIN_W)'(gain_reg);

    // Output split for both channels.
    assign split_cfg.pwm_start   = pwm_start_reg;
    assign split_cfg.analog_full = analog_full_reg;

    clmx_split u_split1 (
        .level_avg (f1_reg),
        .cfg       (split_cfg),
        .result    (split1)
    );

    clmx_split u_split2 (
        .level_avg (f2_reg),
        .cfg       (split_cfg),
        .result    (split2)
    );

    // Sequencer, ring position and running sums.
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        wrapped_next   = wrapped_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                sum_next[AVG_DIMMER] = lane_upd[0];
                sum_next[AVG_COLOUR] = lane_upd[1];
                sum_next[AVG_PRESET] = lane_upd[2];
                state_next = ST_MIX1;
            end
            ST_MIX1:
            begin
                state_next = ST_MIX2;
            end
            ST_MIX2:
            begin
                state_next = ST_MIX3;
            end
            ST_MIX3:
            begin
                state_next = ST_FILT;
            end
            ST_FILT:
            begin
                sum_next[AVG_CH1] = lane_upd[0];
                sum_next[AVG_CH2] = lane_upd[1];
                if (pos_reg == POS_W'(AVERAGE_DEPTH - 1))
                begin
                    pos_next     = '0;
                    wrapped_next = 1'b1;
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
                state_next = ST_SPLIT;
            end
            ST_SPLIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration register decode.
    always_comb
    begin
        pwm_start_next   = pwm_start_reg;
        analog_full_next = analog_full_reg;
        gain_next        = gain_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PWM_START:   pwm_start_next   = cfg_data[START_W-1:0];
                CFG_ANALOG_FULL: analog_full_next = cfg_data[LEVEL_W-1:0];
                CFG_SECOND_GAIN: gain_next        = cfg_data[GAIN_W-1:0];
                default:         ;
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            pos_reg         <= '0;
            wrapped_reg     <= 1'b0;
            sum_reg         <= '0;
            out_valid_reg   <= 1'b0;
            pwm_start_reg   <= PWM_START_RESET;
            analog_full_reg <= ANALOG_FULL_RESET;
            gain_reg        <= GAIN_RESET;
        end
        else
        begin
            state_reg       <= state_next;
            pos_reg         <= pos_next;
            wrapped_reg     <= wrapped_next;
            sum_reg         <= sum_next;
            out_valid_reg   <= out_valid_next;
            pwm_start_reg   <= pwm_start_next;
            analog_full_reg <= analog_full_next;
            gain_reg        <= gain_next;
        end
    end

    // Datapath registers, each loaded in its own step.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            samp_reg[AVG_DIMMER] <= RING_W'(in_data.dimmer_sample) & SAMPLE_MASK;
            samp_reg[AVG_COLOUR] <= RING_W'(in_data.colour_sample) & SAMPLE_MASK;
            samp_reg[AVG_PRESET] <= RING_W'(in_data.preset_sample) & SAMPLE_MASK;
        end
        if (state_reg == ST_READ)
        begin
            d_reg <= d_scaled[MIX_W-1:0];
            c_reg <= c_scaled[MIX_W-1:0];
            p_reg <= p_scaled[PRESET_W-1:0];
        end
        if (state_reg == ST_MIX1)
        begin
            warm_reg <= warm_prod[MIX_W+PRESET_W-1:PRESET_W];
            cold_reg <= cold_prod[MIX_W+PRESET_W-1:PRESET_W];
        end
        if (state_reg == ST_MIX2)
        begin
            ch1_reg <= ch1_prod[2*MIX_W-1:6];
            cd_reg  <= (2*MIX_W)'(cold_reg) * (2*MIX_W)'(d_reg);
        end
        if (state_reg == ST_MIX3)
        begin
            ch2_reg <= ch2_prod[2*MIX_W+GAIN_W-1:14];
        end
        if (state_reg == ST_FILT)
        begin
            f1_reg <= lane_avg[0][LEVEL_W-1:0];
            f2_reg <= lane_avg[1][LEVEL_W-1:0];
        end
        if (state_reg == ST_SPLIT && out_free)
        begin
            out_data_reg.first_soft_duty     <= split1.duty;
            out_data_reg.first_analog_level  <= split1.level;
            out_data_reg.second_soft_duty    <= split2.duty;
            out_data_reg.second_analog_level <= split2.level;
        end
    end

    // A new result appears only from the split step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_SPLIT))
        else $error("result raised outside the split step");

    // Once the ring has wrapped, every row holds written data for good.
    assert property (@(posedge clk) disable iff (!rst_n)
        wrapped_reg |=> wrapped_reg)
        else $error("ring fill flag dropped");

    // The ring position advances exactly once per word, at the write-back.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_FILT) |=> $stable(pos_reg))
        else $error("ring position moved outside write-back");

    // Duties never exceed fully on.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.first_soft_duty <= DUTY_FULL)
                       && (out_data_reg.second_soft_duty <= DUTY_FULL))
        else $error("soft duty beyond fully on");

endmodule

// ===== test/two_channel_led_color_mixer_unit_test.sv =====
`timescale 1ns / 100ps

module two_channel_led_color_mixer_unit_test;

    import clmx_pkg::*;

    localparam int AVG_DEPTH   = DEFAULT_AVERAGE_DEPTH;
    localparam int SAMPLE_W    = DEFAULT_SAMPLE_BITS;
    localparam int SUM_W       = FIELD_W + $clog2(AVG_DEPTH);
    localparam int MIX_SHIFT   = 6;
    localparam int LEVEL_MAX   = (1 << LEVEL_W) - 1;
    localparam int SAMPLE_MAX  = (1 << FIELD_W) - 1;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_WAIT = 28;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_word_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_word_t out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow copy of the mixer: five averaging rings, their sums and the registers.
    logic [FIELD_W-1:0] avg_ring [NUM_AVG][AVG_DEPTH];
    logic [SUM_W-1:0]   avg_sum [NUM_AVG];
    int                 ring_pos = 0;
    logic [START_W-1:0] start_level = PWM_START_RESET;
    logic [LEVEL_W-1:0] full_level = ANALOG_FULL_RESET;
    logic [GAIN_W-1:0]  ch2_gain = GAIN_RESET;

    in_word_t  pending_words [$];
    out_word_t expected_mix [$];
    int        words_queued = 0;
    int        words_accepted = 0;
    int        failures = 0;
    int        quiet_cycles = 0;
    int        in_idle_pct = 0;
    int        out_idle_pct = 0;
    int        in_gap = 0;
    int        out_gap = 0;
    bit        word_taken = 1'b0;

    two_channel_led_color_mixer_unit #(
        .AVERAGE_DEPTH(AVG_DEPTH),
        .SAMPLE_BITS  (SAMPLE_W)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #1 clk = ~clk;

    // Push one value into a ring and return the new average.
    function automatic int unsigned push_average(int slot, int unsigned v);
        avg_sum[slot] = SUM_W'(avg_sum[slot] - avg_ring[slot][ring_pos] + v);
        avg_ring[slot][ring_pos] = FIELD_W'(v);
        return avg_sum[slot] / AVG_DEPTH;
    endfunction

    // Split a filtered channel level into a PWM duty and an analog level.
    function automatic split_out_t split_level(int unsigned f);
        int unsigned s;
        int unsigned a;
        split_out_t  r;
        s = start_level;
        a = full_level;
        r.level = LEVEL_W'(a);
        if (f > s + a) begin
            r.duty  = DUTY_FULL;
            r.level = LEVEL_W'(f - s);
        end
        else if (f >= s) begin
            // With a wide analog range the duty would pass full scale, so clip it.
            r.duty = (f - s > DUTY_FULL) ? DUTY_FULL : DUTY_W'(f - s);
        end
        else begin
            r.duty = '0;
        end
        return r;
    endfunction

    // Expected output word for one input word; advances the shadow state.
    function automatic out_word_t mix_word(in_word_t w);
        int unsigned     dim;
        int unsigned     col;
        int unsigned     pre;
        int unsigned     warm;
        int unsigned     cold;
        int unsigned     ch1;
        int unsigned     ch2;
        longint unsigned prod;
        split_out_t      one;
        split_out_t      two;
        out_word_t       r;
        dim = push_average(AVG_DIMMER, w.dimmer_sample) >> (SAMPLE_W - MIX_W);
        col = push_average(AVG_COLOUR, w.colour_sample) >> (SAMPLE_W - MIX_W);
        pre = push_average(AVG_PRESET, w.preset_sample) >> (SAMPLE_W - PRESET_W);
        dim = dim & MIX_FULL;
        col = col & MIX_FULL;
        pre = pre & ((1 << PRESET_W) - 1);
        warm = ((MIX_FULL - col) * pre) >> MIX_SHIFT;
        cold = (col * pre) >> MIX_SHIFT;
        ch1 = (warm * dim) >> MIX_SHIFT;
        if (ch1 > LEVEL_MAX)
            ch1 = LEVEL_MAX;
        prod = (64'(cold) * dim * ch2_gain) >> (MIX_SHIFT + GAIN_W);
        ch2 = (prod > LEVEL_MAX) ? LEVEL_MAX : int'(prod);
        one = split_level(push_average(AVG_CH1, ch1));
        two = split_level(push_average(AVG_CH2, ch2));
        ring_pos = (ring_pos + 1) % AVG_DEPTH;
        r.first_soft_duty     = one.duty;
        r.first_analog_level  = one.level;
        r.second_soft_duty    = two.duty;
        r.second_analog_level = two.level;
        return r;
    endfunction

    task automatic check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            failures++;
        end
    endtask

    // Sender: holds a word until taken, otherwise idles in bursts or takes the next word.
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else if (!(in_valid && !word_taken)) begin
            if (in_gap > 0) begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if ($urandom_range(0, 99) < in_idle_pct) begin
                in_gap = $urandom_range(0, 6);
                in_valid <= 1'b0;
            end
            else if (pending_words.size() != 0) begin
                in_data  <= pending_words.pop_front();
                in_valid <= 1'b1;
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stalls in bursts, started at random with a chance of out_idle_pct.
    always @(negedge clk) begin
        if (out_gap > 0) begin
            out_gap--;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < out_idle_pct) begin
            out_gap = $urandom_range(0, 6);
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= 1'b1;
        end
    end

    // Monitor: checks output words, then predicts accepted input words.
    always @(posedge clk) begin
        out_word_t want;
        word_taken = rst_n && in_valid && in_ready;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_mix.size() == 0) begin
                    $error("output word arrived with none expected");
                    failures++;
                end
                else begin
                    want = expected_mix.pop_front();
                    check_field("first_soft_duty", want.first_soft_duty,
                                out_data.first_soft_duty);
                    check_field("first_analog_level", want.first_analog_level,
                                out_data.first_analog_level);
                    check_field("second_soft_duty", want.second_soft_duty,
                                out_data.second_soft_duty);
                    check_field("second_analog_level", want.second_analog_level,
                                out_data.second_analog_level);
                end
            end
            if (in_valid && in_ready) begin
                expected_mix.push_back(mix_word(in_data));
                words_accepted++;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_PWM_START:   start_level = cfg_data[START_W-1:0];
                    CFG_ANALOG_FULL: full_level  = cfg_data[LEVEL_W-1:0];
                    CFG_SECOND_GAIN: ch2_gain    = cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Watchdog: ends the run when no word moves on any port for too long.
    always @(posedge clk) begin
        if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready)
                       || (cfg_valid && cfg_ready)))
            quiet_cycles++;
        else
            quiet_cycles = 0;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("two_channel_led_color_mixer_unit verification failed");
            $finish;
        end
    end

    task automatic queue_word(int unsigned d, int unsigned c, int unsigned p);
        in_word_t w;
        w.dimmer_sample = FIELD_W'(d);
        w.colour_sample = FIELD_W'(c);
        w.preset_sample = FIELD_W'(p);
        pending_words.push_back(w);
        words_queued++;
    endtask

    // Waits until every queued word is taken and every result has come back.
    task automatic wait_idle();
        do @(negedge clk);
        while (words_accepted != words_queued || expected_mix.size() != 0);
    endtask

    // Called at a falling edge; returns at a falling edge with the write done.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        do @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic set_mixer(int unsigned start, int unsigned full, int unsigned gain);
        wait_idle();
        write_reg(CFG_PWM_START, start);
        write_reg(CFG_ANALOG_FULL, full);
        write_reg(CFG_SECOND_GAIN, gain);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic int unsigned pick_level();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return SAMPLE_MAX;
            default: return $urandom_range(0, SAMPLE_MAX);
        endcase
    endfunction

    function automatic int unsigned wobble(int unsigned v, int spread);
        int x;
        x = int'(v) + int'($urandom_range(0, 2 * spread)) - spread;
        if (x < 0)
            x = 0;
        if (x > SAMPLE_MAX)
            x = SAMPLE_MAX;
        return x;
    endfunction

    // Mostly steady pot settings held for runs of 8 to 48 words, some long
    // enough to fill the averages, with a share of fully random words in between.
    task automatic queue_random(int count);
        int          left;
        int          run;
        int          spread;
        int unsigned d;
        int unsigned c;
        int unsigned p;
        left = count;
        while (left > 0) begin
            if ($urandom_range(0, 3) == 0) begin
                queue_word($urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX),
                           $urandom_range(0, SAMPLE_MAX));
                left--;
            end
            else begin
                d = pick_level();
                c = pick_level();
                p = pick_level();
                run = $urandom_range(8, 48);
                spread = $urandom_range(0, 64);
                while (run > 0 && left > 0) begin
                    queue_word(wobble(d, spread), wobble(c, spread), wobble(p, spread));
                    run--;
                    left--;
                end
            end
        end
    endtask

    initial begin
        for (int s = 0; s < NUM_AVG; s++) begin
            avg_sum[s] = '0;
            for (int i = 0; i < AVG_DEPTH; i++)
                avg_ring[s][i] = '0;
        end
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the reset register values: field extremes, bit
        // patterns, then full brightness held to lift the channel averages.
        in_idle_pct  = 15;
        out_idle_pct = 15;
        queue_word(0, 0, 0);
        queue_word(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
        queue_word(SAMPLE_MAX, 0, SAMPLE_MAX);
        queue_word(0, SAMPLE_MAX, 0);
        queue_word(SAMPLE_MAX, SAMPLE_MAX, 0);
        queue_word(0, 0, SAMPLE_MAX);
        queue_word(12'hAAA, 12'h555, 12'hAAA);
        queue_word(12'h555, 12'hAAA, 12'h555);
        queue_word(12'h800, 12'h7FF, 12'h001);
        queue_word(12'h001, 12'h800, 12'h7FF);
        repeat (8) queue_word(SAMPLE_MAX, 0, SAMPLE_MAX);
        repeat (6) queue_word(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);

        // Wide analog range with no PWM offset: the duty clips at full scale.
        set_mixer(0, LEVEL_MAX, (1 << GAIN_W) - 1);
        in_idle_pct  = 20;
        out_idle_pct = 20;
        queue_random(120);

        // Highest PWM start and no analog range: channel two gain of zero.
        set_mixer((1 << START_W) - 1, 0, 0);
        in_idle_pct  = 0;
        out_idle_pct = 30;
        queue_random(120);

        // Both bounds at zero: every nonzero level turns the duty fully on and goes straight to analog.
        set_mixer(0, 0, 1 << (GAIN_W - 1));
        in_idle_pct  = 30;
        out_idle_pct = 0;
        queue_random(120);

        // Random registers; the sender pauses midway until the block drains.
        set_mixer($urandom_range(0, (1 << START_W) - 1), $urandom_range(0, LEVEL_MAX),
                  $urandom_range(0, (1 << GAIN_W) - 1));
        in_idle_pct  = 10;
        out_idle_pct = 10;
        queue_random(60);
        wait_idle();
        @(posedge clk);
        queue_random(60);

        set_mixer((1 << START_W) - 1, LEVEL_MAX, (1 << GAIN_W) - 1);
        in_idle_pct  = 20;
        out_idle_pct = 20;
        queue_random(120);

        set_mixer($urandom_range(0, 64), $urandom_range(0, 512),
                  $urandom_range(0, (1 << GAIN_W) - 1));
        in_idle_pct  = 25;
        out_idle_pct = 25;
        queue_random(120);

        // Closing stretch at the power-up values with both sides always ready.
        set_mixer(PWM_START_RESET, ANALOG_FULL_RESET, GAIN_RESET);
        in_idle_pct  = 0;
        out_idle_pct = 0;
        queue_random(130);

        wait_idle();
        repeat (SETTLE_WAIT) @(posedge clk);
        if (failures == 0)
            $display("two_channel_led_color_mixer_unit verification clean");
        else
            $display("two_channel_led_color_mixer_unit verification failed");
        $finish;
    end

endmodule
